[hw/rtl/cpss_pkg.sv]
// Shared widths, latencies and constants for the segment closest-points pipeline.
package cpss_pkg;

  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int TW    = 32;
  localparam int DSW   = 64;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int SW    = PW + 2;
  localparam int WW    = 2 * SW;
  localparam int MW    = FB + 1;
  localparam int PDW   = DW + MW + 1;

  localparam int NLIMB = 3;
  localparam int LIMB  = (SW + NLIMB) / NLIMB;
  localparam int MAW   = NLIMB * LIMB;
  localparam int RW    = (NLIMB + 1) * LIMB;
  localparam int PRW   = 2 * MAW;

  localparam int WMUL_LAT = 5;
  localparam int DIV_LAT  = FB + 1;
  localparam int PIPE_LAT = 12 + 2 * WMUL_LAT + 2 * DIV_LAT;

  localparam logic [MW-1:0] ONE       = {1'b1, {FB{1'b0}}};
  localparam logic [TW-1:0] THR_RESET = TW'(43);

endpackage

[hw/rtl/cpss_wmul.sv]
// Pipelined wide signed multiplier built from limb partial products.
module cpss_wmul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [cpss_pkg::SW-1:0]      a_i,
  input  logic [cpss_pkg::SW-1:0]      b_i,
  output logic [cpss_pkg::WW-1:0]      p_o
);

  logic [3:0]                                   neg_r;
  logic [cpss_pkg::MAW-1:0]                     ma_r, mb_r;
  logic [cpss_pkg::SW-1:0]                      ma_nxt, mb_nxt;
  logic [2*cpss_pkg::LIMB-1:0]                  pp_r [cpss_pkg::NLIMB][cpss_pkg::NLIMB];
  logic [cpss_pkg::RW-1:0]                      row_r [cpss_pkg::NLIMB];
  logic [cpss_pkg::RW-1:0]                      row_nxt [cpss_pkg::NLIMB];
  logic [cpss_pkg::PRW-1:0]                     tot_r, tot_nxt;
  logic [cpss_pkg::WW-1:0]                      p_r;

  always_comb begin
    ma_nxt = a_i[cpss_pkg::SW-1] ? (~a_i + cpss_pkg::SW'(1)) : a_i;
    mb_nxt = b_i[cpss_pkg::SW-1] ? (~b_i + cpss_pkg::SW'(1)) : b_i;
  end

  always_comb begin
    for (int i = 0; i < cpss_pkg::NLIMB; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < cpss_pkg::NLIMB; j++) begin
        row_nxt[i] = row_nxt[i] + (cpss_pkg::RW'(pp_r[i][j]) << (cpss_pkg::LIMB * j));
      end
    end
    tot_nxt = '0;
    for (int i = 0; i < cpss_pkg::NLIMB; i++) begin
      tot_nxt = tot_nxt + (cpss_pkg::PRW'(row_r[i]) << (cpss_pkg::LIMB * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= {neg_r[2:0], a_i[cpss_pkg::SW-1] ^ b_i[cpss_pkg::SW-1]};
      ma_r  <= cpss_pkg::MAW'(ma_nxt);
      mb_r  <= cpss_pkg::MAW'(mb_nxt);
      for (int i = 0; i < cpss_pkg::NLIMB; i++) begin
        for (int j = 0; j < cpss_pkg::NLIMB; j++) begin
          pp_r[i][j] <= ma_r[i*cpss_pkg::LIMB +: cpss_pkg::LIMB]
                      * mb_r[j*cpss_pkg::LIMB +: cpss_pkg::LIMB];
        end
        row_r[i] <= row_nxt[i];
      end
      tot_r <= tot_nxt;
      p_r   <= neg_r[3] ? (~tot_r[cpss_pkg::WW-1:0] + cpss_pkg::WW'(1))
                        : tot_r[cpss_pkg::WW-1:0];
    end
  end

  assign p_o = p_r;

endmodule

[hw/rtl/cpss_div.sv]
// Pipelined restoring divider: clamped quotient num/den in [0,1] with FB fraction bits.
module cpss_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cpss_pkg::WW-1:0]   num_i,
  input  logic [cpss_pkg::WW-1:0]   den_i,
  output logic [cpss_pkg::MW-1:0]   q_o
);

  logic [cpss_pkg::WW-1:0] rem_r [cpss_pkg::FB+1];
  logic [cpss_pkg::WW-1:0] den_r [cpss_pkg::FB+1];
  logic [cpss_pkg::FB-1:0] q_r   [cpss_pkg::FB+1];
  logic [cpss_pkg::FB:0]   zero_r, sat_r;
  logic [cpss_pkg::WW:0]   dif_w [cpss_pkg::FB+1];
  logic [cpss_pkg::WW-1:0] sh_w  [cpss_pkg::FB+1];

  always_comb begin
    sh_w[0]  = '0;
    dif_w[0] = '0;
    for (int k = 1; k <= cpss_pkg::FB; k++) begin
      sh_w[k]  = {rem_r[k-1][cpss_pkg::WW-2:0], 1'b0};
      dif_w[k] = {1'b0, sh_w[k]} - {1'b0, den_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= den_i[cpss_pkg::WW-1] || (den_i == '0) || num_i[cpss_pkg::WW-1]
                   || (num_i == '0);
      sat_r[0]  <= $signed(num_i) >= $signed(den_i);
      rem_r[0]  <= num_i;
      den_r[0]  <= den_i;
      q_r[0]    <= '0;
      for (int k = 1; k <= cpss_pkg::FB; k++) begin
        rem_r[k]  <= dif_w[k][cpss_pkg::WW] ? sh_w[k] : dif_w[k][cpss_pkg::WW-1:0];
        q_r[k]    <= {q_r[k-1][cpss_pkg::FB-2:0], ~dif_w[k][cpss_pkg::WW]};
        den_r[k]  <= den_r[k-1];
        zero_r[k] <= zero_r[k-1];
        sat_r[k]  <= sat_r[k-1];
      end
    end
  end

  assign q_o = zero_r[cpss_pkg::FB] ? '0 :
               sat_r[cpss_pkg::FB]  ? cpss_pkg::ONE : {1'b0, q_r[cpss_pkg::FB]};

endmodule

[hw/rtl/closest_points_between_segments.sv]
// Top level: closest points and squared distance between two 3D segments.
// One word enters per cycle while in_stall is low, and each word gives one
// result word; its path runs through the two 17-stage dividers and the two 5-stage
// wide multipliers in the chain. A two-word output buffer lets the pipeline
// keep taking words while a result waits; in_stall rises only once both
// output places are full. degenerate_threshold (reset 43) is written through
// cfg_wr_en/cfg_wr_data and should only change while the pipeline is empty.
module closest_points_between_segments (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [cpss_pkg::TW-1:0]      cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_a_start_x,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_a_start_y,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_a_start_z,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_a_end_x,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_a_end_y,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_a_end_z,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_b_start_x,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_b_start_y,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_b_start_z,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_b_end_x,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_b_end_y,
  input  logic signed [cpss_pkg::CW-1:0] in_seg_b_end_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cpss_pkg::MW-1:0]      out_param_a,
  output logic [cpss_pkg::MW-1:0]      out_param_b,
  output logic signed [cpss_pkg::CW-1:0] out_near_a_x,
  output logic signed [cpss_pkg::CW-1:0] out_near_a_y,
  output logic signed [cpss_pkg::CW-1:0] out_near_a_z,
  output logic signed [cpss_pkg::CW-1:0] out_near_b_x,
  output logic signed [cpss_pkg::CW-1:0] out_near_b_y,
  output logic signed [cpss_pkg::CW-1:0] out_near_b_z,
  output logic [cpss_pkg::DSW-1:0]     out_dist_sq
);

  typedef struct packed {
    logic [2:0][cpss_pkg::CW-1:0] pa;
    logic [2:0][cpss_pkg::CW-1:0] pb;
    logic [2:0][cpss_pkg::DW-1:0] da;
    logic [2:0][cpss_pkg::DW-1:0] db;
  } geo_t;

  typedef struct packed {
    geo_t                         g;
    logic [2:0][cpss_pkg::DW-1:0] rr;
  } st1_t;

  typedef struct packed {
    geo_t                         g;
    logic [2:0][cpss_pkg::PW-1:0] paa, pbb, pcc, pee, pff;
  } st2_t;

  typedef struct packed {
    geo_t                    g;
    logic [cpss_pkg::SW-1:0] a, b, c, e, f;
    logic                    adeg, edeg;
  } sd_t;

  typedef struct packed {
    sd_t                     sd;
    logic [cpss_pkg::WW-1:0] den, num;
  } st4_t;

  typedef struct packed {
    sd_t                     sd;
    logic [cpss_pkg::MW-1:0] s1;
  } sd3_t;

  typedef struct packed {
    sd3_t                    x;
    logic [cpss_pkg::WW-1:0] numt;
  } st6_t;

  typedef enum logic {ROUTE_S, ROUTE_T} route_t;

  typedef struct packed {
    geo_t                    g;
    route_t                  route;
    logic [cpss_pkg::MW-1:0] fixv;
  } sel_t;

  typedef struct packed {
    sel_t                    sel;
    logic [cpss_pkg::WW-1:0] num, den;
  } st7_t;

  typedef struct packed {
    geo_t                    g;
    logic [cpss_pkg::MW-1:0] s, t;
  } st8_t;

  typedef struct packed {
    logic [2:0][cpss_pkg::CW-1:0]  pa, pb;
    logic [cpss_pkg::MW-1:0]       s, t;
    logic [2:0][cpss_pkg::PDW-1:0] pda, pdb;
  } st9_t;

  typedef struct packed {
    logic [cpss_pkg::MW-1:0]      s, t;
    logic [2:0][cpss_pkg::CW-1:0] ca, cb;
  } pt_t;

  typedef struct packed {
    pt_t                          p;
    logic [2:0][cpss_pkg::DW-1:0] dd;
  } st11_t;

  typedef struct packed {
    pt_t                          p;
    logic [2:0][cpss_pkg::PW-1:0] sq;
  } st12_t;

  typedef struct packed {
    pt_t                      p;
    logic [cpss_pkg::DSW-1:0] dsq;
  } res_t;

  function automatic logic [cpss_pkg::SW-1:0] sx_p(input logic [cpss_pkg::PW-1:0] v);
    return {{(cpss_pkg::SW-cpss_pkg::PW){v[cpss_pkg::PW-1]}}, v};
  endfunction

  function automatic logic [cpss_pkg::WW-1:0] sx_w(input logic [cpss_pkg::SW-1:0] v);
    return {{(cpss_pkg::WW-cpss_pkg::SW){v[cpss_pkg::SW-1]}}, v};
  endfunction

  logic [cpss_pkg::TW-1:0]       thr_r;
  logic                          en;
  logic [cpss_pkg::PIPE_LAT-1:0] vld_r;
  logic                          p_v;
  logic                          out_v_r, skid_v_r;
  res_t                          out_r, skid_r;

  logic [2:0][cpss_pkg::CW-1:0]  in_a0, in_a1, in_b0, in_b1;

  st1_t  st1_r, st1_nxt;
  st2_t  st2_r, st2_nxt;
  sd_t   st3_r, st3_nxt;
  sd_t   d1_r [cpss_pkg::WMUL_LAT];
  st4_t  st4_r, st4_nxt;
  sd_t   d2_r [cpss_pkg::DIV_LAT];
  sd3_t  d3_in;
  sd3_t  d3_r [cpss_pkg::WMUL_LAT];
  st6_t  st6_r, st6_nxt;
  st7_t  st7_r, st7_nxt;
  sel_t  d4_r [cpss_pkg::DIV_LAT];
  st8_t  st8_r, st8_nxt;
  st9_t  st9_r, st9_nxt;
  pt_t   st10_r, st10_nxt;
  st11_t st11_r, st11_nxt;
  st12_t st12_r, st12_nxt;
  res_t  st13_r, st13_nxt;

  logic [cpss_pkg::WW-1:0] pae, pbb, pbf, pce, pbs;
  logic [cpss_pkg::MW-1:0] q1, q2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= cpss_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  assign en       = ~skid_v_r;
  assign in_stall = skid_v_r;
  assign p_v      = vld_r[cpss_pkg::PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[cpss_pkg::PIPE_LAT-2:0], in_valid};
    end
  end

  assign in_a0 = {in_seg_a_start_z, in_seg_a_start_y, in_seg_a_start_x};
  assign in_a1 = {in_seg_a_end_z,   in_seg_a_end_y,   in_seg_a_end_x};
  assign in_b0 = {in_seg_b_start_z, in_seg_b_start_y, in_seg_b_start_x};
  assign in_b1 = {in_seg_b_end_z,   in_seg_b_end_y,   in_seg_b_end_x};

  // directions and start offset
  always_comb begin
    st1_nxt.g.pa = in_a0;
    st1_nxt.g.pb = in_b0;
    for (int k = 0; k < 3; k++) begin
      st1_nxt.g.da[k] = {in_a1[k][cpss_pkg::CW-1], in_a1[k]}
                      - {in_a0[k][cpss_pkg::CW-1], in_a0[k]};
      st1_nxt.g.db[k] = {in_b1[k][cpss_pkg::CW-1], in_b1[k]}
                      - {in_b0[k][cpss_pkg::CW-1], in_b0[k]};
      st1_nxt.rr[k]   = {in_a0[k][cpss_pkg::CW-1], in_a0[k]}
                      - {in_b0[k][cpss_pkg::CW-1], in_b0[k]};
    end
  end

  // component products
  always_comb begin
    st2_nxt.g = st1_r.g;
    for (int k = 0; k < 3; k++) begin
      st2_nxt.paa[k] = $signed(st1_r.g.da[k]) * $signed(st1_r.g.da[k]);
      st2_nxt.pbb[k] = $signed(st1_r.g.da[k]) * $signed(st1_r.g.db[k]);
      st2_nxt.pcc[k] = $signed(st1_r.g.da[k]) * $signed(st1_r.rr[k]);
      st2_nxt.pee[k] = $signed(st1_r.g.db[k]) * $signed(st1_r.g.db[k]);
      st2_nxt.pff[k] = $signed(st1_r.g.db[k]) * $signed(st1_r.rr[k]);
    end
  end

  // dot products
  always_comb begin
    st3_nxt.g    = st2_r.g;
    st3_nxt.a    = sx_p(st2_r.paa[0]) + sx_p(st2_r.paa[1]) + sx_p(st2_r.paa[2]);
    st3_nxt.b    = sx_p(st2_r.pbb[0]) + sx_p(st2_r.pbb[1]) + sx_p(st2_r.pbb[2]);
    st3_nxt.c    = sx_p(st2_r.pcc[0]) + sx_p(st2_r.pcc[1]) + sx_p(st2_r.pcc[2]);
    st3_nxt.e    = sx_p(st2_r.pee[0]) + sx_p(st2_r.pee[1]) + sx_p(st2_r.pee[2]);
    st3_nxt.f    = sx_p(st2_r.pff[0]) + sx_p(st2_r.pff[1]) + sx_p(st2_r.pff[2]);
    st3_nxt.adeg = 1'b0;
    st3_nxt.edeg = 1'b0;
  end

  cpss_wmul u_mul_ae (.clk(clk), .en(en), .a_i(st3_r.a), .b_i(st3_r.e), .p_o(pae));
  cpss_wmul u_mul_bb (.clk(clk), .en(en), .a_i(st3_r.b), .b_i(st3_r.b), .p_o(pbb));
  cpss_wmul u_mul_bf (.clk(clk), .en(en), .a_i(st3_r.b), .b_i(st3_r.f), .p_o(pbf));
  cpss_wmul u_mul_ce (.clk(clk), .en(en), .a_i(st3_r.c), .b_i(st3_r.e), .p_o(pce));

  // degenerate tests, line-line numerator and denominator
  always_comb begin
    st4_nxt.sd      = d1_r[cpss_pkg::WMUL_LAT-1];
    st4_nxt.sd.adeg = d1_r[cpss_pkg::WMUL_LAT-1].a <= cpss_pkg::SW'(thr_r);
    st4_nxt.sd.edeg = d1_r[cpss_pkg::WMUL_LAT-1].e <= cpss_pkg::SW'(thr_r);
    st4_nxt.den     = pae - pbb;
    st4_nxt.num     = pbf - pce;
  end

  cpss_div u_div_s (.clk(clk), .en(en), .num_i(st4_r.num), .den_i(st4_r.den), .q_o(q1));

  cpss_wmul u_mul_bs (
    .clk (clk),
    .en  (en),
    .a_i (d2_r[cpss_pkg::DIV_LAT-1].b),
    .b_i ({{(cpss_pkg::SW-cpss_pkg::MW){1'b0}}, q1}),
    .p_o (pbs)
  );

  assign d3_in = '{sd: d2_r[cpss_pkg::DIV_LAT-1], s1: q1};

  always_comb begin
    st6_nxt.x    = d3_r[cpss_pkg::WMUL_LAT-1];
    st6_nxt.numt = pbs + (sx_w(d3_r[cpss_pkg::WMUL_LAT-1].sd.f) << cpss_pkg::FB);
  end

  // pick the second quotient and where it goes
  always_comb begin
    logic [cpss_pkg::WW-1:0] esc, negc, bmc, wa;
    sd_t                     sd;
    sd   = st6_r.x.sd;
    esc  = {{(cpss_pkg::WW-cpss_pkg::SW){1'b0}}, sd.e} << cpss_pkg::FB;
    negc = '0 - sx_w(sd.c);
    bmc  = sx_w(sd.b) - sx_w(sd.c);
    wa   = sx_w(sd.a);
    st7_nxt.sel.g = sd.g;
    priority if (sd.adeg && sd.edeg) begin
      st7_nxt.sel.route = ROUTE_S;
      st7_nxt.sel.fixv  = '0;
      st7_nxt.num       = '0;
      st7_nxt.den       = esc;
    end else if (sd.adeg) begin
      st7_nxt.sel.route = ROUTE_T;
      st7_nxt.sel.fixv  = '0;
      st7_nxt.num       = sx_w(sd.f);
      st7_nxt.den       = sx_w(sd.e);
    end else if (sd.edeg || st6_r.numt[cpss_pkg::WW-1]) begin
      st7_nxt.sel.route = ROUTE_S;
      st7_nxt.sel.fixv  = '0;
      st7_nxt.num       = negc;
      st7_nxt.den       = wa;
    end else if ($signed(st6_r.numt) > $signed(esc)) begin
      st7_nxt.sel.route = ROUTE_S;
      st7_nxt.sel.fixv  = cpss_pkg::ONE;
      st7_nxt.num       = bmc;
      st7_nxt.den       = wa;
    end else begin
      st7_nxt.sel.route = ROUTE_T;
      st7_nxt.sel.fixv  = st6_r.x.s1;
      st7_nxt.num       = st6_r.numt;
      st7_nxt.den       = esc;
    end
  end

  cpss_div u_div_2 (.clk(clk), .en(en), .num_i(st7_r.num), .den_i(st7_r.den), .q_o(q2));

  always_comb begin
    sel_t sl;
    sl        = d4_r[cpss_pkg::DIV_LAT-1];
    st8_nxt.g = sl.g;
    st8_nxt.s = (sl.route == ROUTE_S) ? q2 : sl.fixv;
    st8_nxt.t = (sl.route == ROUTE_T) ? q2 : sl.fixv;
  end

  // interpolation
  always_comb begin
    st9_nxt.pa = st8_r.g.pa;
    st9_nxt.pb = st8_r.g.pb;
    st9_nxt.s  = st8_r.s;
    st9_nxt.t  = st8_r.t;
    for (int k = 0; k < 3; k++) begin
      st9_nxt.pda[k] = $signed(st8_r.g.da[k]) * $signed({1'b0, st8_r.s});
      st9_nxt.pdb[k] = $signed(st8_r.g.db[k]) * $signed({1'b0, st8_r.t});
    end
  end

  always_comb begin
    logic signed [cpss_pkg::PDW-1:0] ta, tb;
    ta = '0;
    tb = '0;
    st10_nxt.s = st9_r.s;
    st10_nxt.t = st9_r.t;
    for (int k = 0; k < 3; k++) begin
      ta = ($signed(st9_r.pda[k]) >>> cpss_pkg::FB)
         + $signed({{(cpss_pkg::PDW-cpss_pkg::CW){st9_r.pa[k][cpss_pkg::CW-1]}}, st9_r.pa[k]});
      tb = ($signed(st9_r.pdb[k]) >>> cpss_pkg::FB)
         + $signed({{(cpss_pkg::PDW-cpss_pkg::CW){st9_r.pb[k][cpss_pkg::CW-1]}}, st9_r.pb[k]});
      st10_nxt.ca[k] = ta[cpss_pkg::CW-1:0];
      st10_nxt.cb[k] = tb[cpss_pkg::CW-1:0];
    end
  end

  // distance
  always_comb begin
    st11_nxt.p = st10_r;
    for (int k = 0; k < 3; k++) begin
      st11_nxt.dd[k] = {st10_r.ca[k][cpss_pkg::CW-1], st10_r.ca[k]}
                     - {st10_r.cb[k][cpss_pkg::CW-1], st10_r.cb[k]};
    end
  end

  always_comb begin
    st12_nxt.p = st11_r.p;
    for (int k = 0; k < 3; k++) begin
      st12_nxt.sq[k] = $signed(st11_r.dd[k]) * $signed(st11_r.dd[k]);
    end
  end

  always_comb begin
    logic [cpss_pkg::SW-1:0] sum;
    sum = cpss_pkg::SW'(st12_r.sq[0]) + cpss_pkg::SW'(st12_r.sq[1])
        + cpss_pkg::SW'(st12_r.sq[2]);
    st13_nxt.p   = st12_r.p;
    st13_nxt.dsq = (|sum[cpss_pkg::SW-1:cpss_pkg::DSW]) ? '1 : sum[cpss_pkg::DSW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r    <= st1_nxt;
      st2_r    <= st2_nxt;
      st3_r    <= st3_nxt;
      d1_r[0]  <= st3_r;
      for (int i = 1; i < cpss_pkg::WMUL_LAT; i++) begin
        d1_r[i] <= d1_r[i-1];
        d3_r[i] <= d3_r[i-1];
      end
      st4_r    <= st4_nxt;
      d2_r[0]  <= st4_r.sd;
      d4_r[0]  <= st7_r.sel;
      for (int i = 1; i < cpss_pkg::DIV_LAT; i++) begin
        d2_r[i] <= d2_r[i-1];
        d4_r[i] <= d4_r[i-1];
      end
      d3_r[0]  <= d3_in;
      st6_r    <= st6_nxt;
      st7_r    <= st7_nxt;
      st8_r    <= st8_nxt;
      st9_r    <= st9_nxt;
      st10_r   <= st10_nxt;
      st11_r   <= st11_nxt;
      st12_r   <= st12_nxt;
      st13_r   <= st13_nxt;
    end
  end

  // output register with skid buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && out_stall) begin
      if (!skid_v_r && p_v) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && out_stall) begin
      if (!skid_v_r) begin
        skid_r <= st13_r;
      end
    end else if (skid_v_r) begin
      out_r <= skid_r;
    end else begin
      out_r <= st13_r;
    end
  end

  assign out_valid    = out_v_r;
  assign out_param_a  = out_r.p.s;
  assign out_param_b  = out_r.p.t;
  assign out_near_a_x = out_r.p.ca[0];
  assign out_near_a_y = out_r.p.ca[1];
  assign out_near_a_z = out_r.p.ca[2];
  assign out_near_b_x = out_r.p.cb[0];
  assign out_near_b_y = out_r.p.cb[1];
  assign out_near_b_z = out_r.p.cb[2];
  assign out_dist_sq  = out_r.dsq;

  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.p.s <= cpss_pkg::ONE) && (out_r.p.t <= cpss_pkg::ONE))
    else $error("clamped parameter out of range");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall && p_v))
    else $error("skid filled without a stalled output");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the segment closest-points pipeline.
`timescale 1ns / 1ps

typedef logic signed [cpss_pkg::CW-1:0] coord_t;
typedef logic signed [255:0] big_t;

typedef struct {
  coord_t c[12];
} seg_pair_t;

typedef struct {
  logic [cpss_pkg::MW-1:0]  param_a;
  logic [cpss_pkg::MW-1:0]  param_b;
  coord_t                   near[6];
  logic [cpss_pkg::DSW-1:0] dist_sq;
} closest_t;

class closest_pair_scoreboard;
  closest_t                expected_q[$];
  logic [cpss_pkg::TW-1:0] threshold = cpss_pkg::THR_RESET;
  int                      mismatches = 0;
  int                      matched = 0;

  function automatic logic [cpss_pkg::MW-1:0] ratio_clamp(big_t n, big_t d);
    if (d <= 0 || n <= 0) return '0;
    if (n >= d) return cpss_pkg::ONE;
    return cpss_pkg::MW'((n <<< cpss_pkg::FB) / d);
  endfunction

  function automatic big_t dot(big_t u[3], big_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic closest_t predict_closest(seg_pair_t p);
    closest_t r;
    big_t pa[3], pb[3], da[3], db[3], rr[3], ca, cb, dd;
    big_t a, b, c, e, f, thr, den, numt, ws, wt, dsq;
    logic [cpss_pkg::MW-1:0] s, t;
    logic a_pt, b_pt;
    for (int k = 0; k < 3; k++) begin
      pa[k] = p.c[k];
      da[k] = big_t'(p.c[3+k]) - pa[k];
      pb[k] = p.c[6+k];
      db[k] = big_t'(p.c[9+k]) - pb[k];
      rr[k] = pa[k] - pb[k];
    end
    a = dot(da, da);
    e = dot(db, db);
    f = dot(db, rr);
    c = dot(da, rr);
    b = dot(da, db);
    thr = {224'd0, threshold};
    a_pt = a <= thr;
    b_pt = e <= thr;
    if (a_pt && b_pt) begin
      s = '0; t = '0;
    end else if (a_pt) begin
      s = '0; t = ratio_clamp(f, e);
    end else if (b_pt) begin
      t = '0; s = ratio_clamp(-c, a);
    end else begin
      den = a * e - b * b;
      s = ratio_clamp(b * f - c * e, den);
      ws = {239'd0, s};
      numt = b * ws + (f <<< cpss_pkg::FB);
      if (numt < 0) begin
        t = '0; s = ratio_clamp(-c, a);
      end else if (numt > (e <<< cpss_pkg::FB)) begin
        t = cpss_pkg::ONE; s = ratio_clamp(b - c, a);
      end else begin
        t = ratio_clamp(numt, e <<< cpss_pkg::FB);
      end
    end
    ws = {239'd0, s};
    wt = {239'd0, t};
    dsq = 0;
    for (int k = 0; k < 3; k++) begin
      ca = pa[k] + ((da[k] * ws) >>> cpss_pkg::FB);
      cb = pb[k] + ((db[k] * wt) >>> cpss_pkg::FB);
      dd = ca - cb;
      dsq = dsq + dd * dd;
      r.near[k] = ca[cpss_pkg::CW-1:0];
      r.near[3+k] = cb[cpss_pkg::CW-1:0];
    end
    r.param_a = s;
    r.param_b = t;
    r.dist_sq = (dsq[255:cpss_pkg::DSW] != 0) ? '1 : dsq[cpss_pkg::DSW-1:0];
    return r;
  endfunction

  function void note_pair(seg_pair_t p);
    expected_q = {expected_q, predict_closest(p)};
  endfunction

  function void check_result(closest_t got);
    closest_t x;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result word, dist_sq %h", $time, got.dist_sq);
      mismatches++;
      return;
    end
    x = expected_q.pop_front();
    if (got.param_a !== x.param_a) begin
      $display("%0t: param_a exp %h got %h", $time, x.param_a, got.param_a);
      mismatches++;
    end
    if (got.param_b !== x.param_b) begin
      $display("%0t: param_b exp %h got %h", $time, x.param_b, got.param_b);
      mismatches++;
    end
    for (int k = 0; k < 6; k++)
      if (got.near[k] !== x.near[k]) begin
        $display("%0t: near[%0d] exp %h got %h", $time, k, x.near[k], got.near[k]);
        mismatches++;
      end
    if (got.dist_sq !== x.dist_sq) begin
      $display("%0t: dist_sq exp %h got %h", $time, x.dist_sq, got.dist_sq);
      mismatches++;
    end
    matched++;
  endfunction
endclass

module tb_top;

  localparam coord_t CMAX = {1'b0, {(cpss_pkg::CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(cpss_pkg::CW-1){1'b0}}};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [cpss_pkg::TW-1:0]  cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  coord_t                   in_c[12] = '{default: '0};
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [cpss_pkg::MW-1:0]  out_param_a, out_param_b;
  coord_t                   out_near[6];
  logic [cpss_pkg::DSW-1:0] out_dist_sq;

  int send_idle = 0;
  int recv_idle = 0;
  int sent = 0;
  closest_pair_scoreboard sb = new();

  always #4 clk = ~clk;

  closest_points_between_segments dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_seg_a_start_x(in_c[0]), .in_seg_a_start_y(in_c[1]), .in_seg_a_start_z(in_c[2]),
    .in_seg_a_end_x(in_c[3]), .in_seg_a_end_y(in_c[4]), .in_seg_a_end_z(in_c[5]),
    .in_seg_b_start_x(in_c[6]), .in_seg_b_start_y(in_c[7]), .in_seg_b_start_z(in_c[8]),
    .in_seg_b_end_x(in_c[9]), .in_seg_b_end_y(in_c[10]), .in_seg_b_end_z(in_c[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_param_a(out_param_a), .out_param_b(out_param_b),
    .out_near_a_x(out_near[0]), .out_near_a_y(out_near[1]), .out_near_a_z(out_near[2]),
    .out_near_b_x(out_near[3]), .out_near_b_y(out_near[4]), .out_near_b_z(out_near[5]),
    .out_dist_sq(out_dist_sq)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // values settle by the falling edge; the word moves at the next rising edge
  always @(negedge clk) begin
    closest_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.param_a = out_param_a;
      got.param_b = out_param_b;
      got.near = out_near;
      got.dist_sq = out_dist_sq;
      sb.check_result(got);
    end
  end

  task automatic send_pair(seg_pair_t p);
    logic taken;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_c <= p.c;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_pair(p);
    sent++;
  endtask

  task automatic drain_and_write(logic [cpss_pkg::TW-1:0] thr);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (cpss_pkg::PIPE_LAT + 10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.threshold = thr;
    @(posedge clk);
  endtask

  function automatic coord_t small_coord();
    return coord_t'($signed($urandom_range(1 << 19)) - (1 << 18));
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int kind = $urandom_range(9);
    int m;
    for (int i = 0; i < 12; i++) p.c[i] = (kind < 3) ? coord_t'($urandom) : small_coord();
    unique case (kind)
      5: for (int i = 0; i < 3; i++) p.c[3+i] = p.c[i] + $signed($urandom_range(6)) - 3;
      6: for (int i = 0; i < 3; i++) p.c[9+i] = p.c[6+i] + $signed($urandom_range(6)) - 3;
      7: begin
        m = $signed($urandom_range(6)) - 3;
        for (int i = 0; i < 3; i++) p.c[9+i] = p.c[6+i] + m * (p.c[3+i] - p.c[i]);
      end
      8: for (int i = 0; i < 12; i++) p.c[i] = $urandom_range(1) ? CMAX : CMIN;
      default: ;
    endcase
    return p;
  endfunction

  function automatic seg_pair_t make_pair(int v[12]);
    seg_pair_t p;
    for (int i = 0; i < 12; i++) p.c[i] = coord_t'(v[i] * 65536);
    return p;
  endfunction

  initial begin
    seg_pair_t p;
    int unit = 65536;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, both points, A point, B point, parallel, crossing, clamps
    send_pair(make_pair('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
    send_pair(make_pair('{1,2,3, 1,2,3, 4,5,6, 4,5,6}));
    send_pair(make_pair('{1,1,1, 1,1,1, 0,0,0, 4,0,0}));
    send_pair(make_pair('{-3,0,0, 5,0,0, 2,3,0, 2,3,0}));
    send_pair(make_pair('{0,0,0, 4,0,0, 0,1,0, 4,1,0}));
    send_pair(make_pair('{0,0,0, 4,0,0, 6,1,0, 9,1,0}));
    send_pair(make_pair('{-2,0,0, 2,0,0, 0,-2,1, 0,2,1}));
    send_pair(make_pair('{0,0,0, 2,0,0, 5,-1,0, 5,1,0}));
    send_pair(make_pair('{0,0,0, 4,0,0, 1,1,0, 6,9,0}));
    send_pair(make_pair('{0,0,0, 4,0,0, -3,2,0, 1,1,0}));
    send_pair(make_pair('{0,0,0, 4,4,0, 2,2,0, 2,2,5}));
    for (int i = 0; i < 12; i++) p.c[i] = CMAX;
    send_pair(p);
    for (int i = 0; i < 12; i++) p.c[i] = CMIN;
    send_pair(p);
    for (int i = 0; i < 12; i++) p.c[i] = (i < 6) ? CMAX : CMIN;
    send_pair(p);
    for (int i = 0; i < 12; i++) p.c[i] = (i % 2) ? CMAX : CMIN;
    send_pair(p);
    for (int i = 0; i < 12; i++) p.c[i] = (i % 3 == 0) ? coord_t'('1) : coord_t'(unit / 2 + i);
    send_pair(p);
    for (int i = 0; i < 12; i++) p.c[i] = (i == 3 || i == 9) ? coord_t'(6) : coord_t'(0);
    send_pair(p);

    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin drain_and_write('0);  send_idle = 18; recv_idle = 71; end
        1: begin drain_and_write('1);  send_idle = 71; recv_idle = 18; end
        2: begin
          drain_and_write(cpss_pkg::TW'($urandom_range(1 << 30)));
          send_idle = 0; recv_idle = 0;
        end
        default: begin
          drain_and_write(cpss_pkg::THR_RESET);
          send_idle = 0; recv_idle = 0;
        end
      endcase
      repeat (321) send_pair(random_pair());
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (cpss_pkg::PIPE_LAT + 10) @(posedge clk);
    $display("Sent %0d segment pairs over five threshold settings, %0d results checked.",
             sent, sb.matched);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results outstanding.", sb.expected_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
